// ===== design/led_strip_frame_serializer_macros.svh =====
// ---------------------------------------------------------------------------
// LED strip frame serializer assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef LED_STRIP_FRAME_SERIALIZER_MACROS_SVH
`define LED_STRIP_FRAME_SERIALIZER_MACROS_SVH

// Same-cycle implication.
`define LSFS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("led strip serializer assertion failed");

// Next-cycle implication.
`define LSFS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("led strip serializer assertion failed");

`endif

// ===== design/lsfs_pkg.sv =====
// ---------------------------------------------------------------------------
// LED strip frame serializer package
// Field widths, function codes, constants and controller interface structs.
// ---------------------------------------------------------------------------
package lsfs_pkg;

  // Field widths.
  localparam int CFG_W      = 11;
  localparam int FUNC_W     = 2;
  localparam int PIX_IDX_W  = 10;
  localparam int COLOR_W    = 8;

  // Defaults and fixed constants.
  localparam int              MAX_LEDS_DEFAULT = 1024;
  localparam logic [CFG_W-1:0] LED_COUNT_RESET = 11'd32;
  localparam logic [COLOR_W-1:0] OFF_BYTE      = 8'h80;
  localparam logic [COLOR_W-1:0] TOP_BIT       = 8'h80;
  localparam int              LATCH_ROUND      = 31;
  localparam int              LATCH_SHIFT      = 5;
  localparam int              BYTES_PER_LED    = 3;

  // Input function codes.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_SET_PIXEL = 2'd0,
    FUNC_SHOW      = 2'd1,
    FUNC_LATCH     = 2'd2,
    FUNC_TICK      = 2'd3
  } func_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic pix_write;
    logic start;
    logic data_phase;
    logic tick;
  } lsfs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic count_zero;
    logic pix_ok;
    logic data_last;
    logic latch_last;
    logic out_busy;
  } lsfs_status_t;

endpackage

// ===== design/lsfs_ctrl.sv =====
// ---------------------------------------------------------------------------
// LED strip frame serializer controller
// Sequences the store clearing pass, pixel writes and the data and latch
// phases of a frame, and issues commands to the datapath.
// ---------------------------------------------------------------------------
module lsfs_ctrl
  import lsfs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [FUNC_W-1:0]  func_i,
  input  lsfs_status_t       status_i,
  output lsfs_cmd_t          cmd_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DATA,
    ST_LATCH
  } state_e;

  state_e state_q, state_d;
  logic   accept;
  func_e  func;

  assign func = func_e'(func_i);

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q != ST_CLEAR) && !status_i.out_busy;
    accept     = in_valid_i && in_ready_o;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (func)
            FUNC_SET_PIXEL: begin
              cmd_o.pix_write = status_i.pix_ok;
            end
            FUNC_SHOW: begin
              if (!status_i.count_zero) begin
                cmd_o.start = 1'b1;
                state_d     = ST_DATA;
              end
            end
            FUNC_LATCH: begin
              if (!status_i.count_zero) begin
                cmd_o.start = 1'b1;
                state_d     = ST_LATCH;
              end
            end
            FUNC_TICK: begin
              // A tick while idle produces nothing.
            end
          endcase
        end
      end
      ST_DATA: begin
        cmd_o.data_phase = 1'b1;
        if (accept && (func == FUNC_TICK)) begin
          cmd_o.tick = 1'b1;
          if (status_i.data_last) begin
            state_d = ST_LATCH;
          end
        end
      end
      ST_LATCH: begin
        if (accept && (func == FUNC_TICK)) begin
          cmd_o.tick = 1'b1;
          if (status_i.latch_last) begin
            state_d = ST_IDLE;
          end
        end
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/lsfs_datapath.sv =====
// ---------------------------------------------------------------------------
// LED strip frame serializer datapath
// Pixel store, count register, frame position counters, shift register and
// the output register for serial bits.
// ---------------------------------------------------------------------------
module lsfs_datapath
  import lsfs_pkg::*;
#(
  parameter int MAX_LEDS = MAX_LEDS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_W-1:0]     cfg_led_count_i,
  input  logic [PIX_IDX_W-1:0] pixel_index_i,
  input  logic [COLOR_W-1:0]   red_i,
  input  logic [COLOR_W-1:0]   green_i,
  input  logic [COLOR_W-1:0]   blue_i,
  input  lsfs_cmd_t            cmd_i,
  output lsfs_status_t         status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 data_bit_o,
  output logic                 last_bit_o
);

  localparam int ROW_W   = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CNT_W   = $clog2(MAX_LEDS + 1);
  localparam int CMP_W   = (CFG_W > CNT_W) ? CFG_W : CNT_W;
  localparam int PCMP_W  = (PIX_IDX_W > CNT_W) ? PIX_IDX_W : CNT_W;
  localparam int LB_MAX  = (MAX_LEDS + LATCH_ROUND) / (1 << LATCH_SHIFT);
  localparam int LB_W    = (LB_MAX > 1) ? $clog2(LB_MAX) : 1;
  localparam int ROW_BITS = BYTES_PER_LED * COLOR_W;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(MAX_LEDS - 1);
  localparam logic [1:0] LAST_BYTE = 2'(BYTES_PER_LED - 1);

  logic [CFG_W-1:0]    led_count_q;
  logic [CNT_W-1:0]    count_use;
  logic [CMP_W-1:0]    cfg_ext;
  logic [CNT_W:0]      lb_round;
  logic [CNT_W:0]      lb_full;

  logic [ROW_W-1:0]    clr_q;
  logic [ROW_W-1:0]    led_q, led_d;
  logic [1:0]          byte_q, byte_d;
  logic [2:0]          bit_q, bit_d;
  logic [LB_W-1:0]     lb_cnt_q, lb_cnt_d;
  logic [ROW_W-1:0]    led_last_q;
  logic [LB_W-1:0]     lb_last_q;
  logic [COLOR_W-1:0]  shift_q, shift_d;

  logic [ROW_BITS-1:0] mem_q [MAX_LEDS];
  logic [ROW_BITS-1:0] rd_q;
  logic                wr_en;
  logic [ROW_W-1:0]    wr_addr;
  logic [ROW_BITS-1:0] wr_data;

  logic [COLOR_W-1:0]  cur_byte;
  logic [COLOR_W-1:0]  src_byte;
  logic                bit_v;
  logic                byte_end;

  logic                out_valid_q;
  logic                data_bit_q;
  logic                last_bit_q;

  // Count in use, saturated at the store size, and the frame lengths.
  assign cfg_ext   = CMP_W'(led_count_q);
  assign count_use = (cfg_ext > CMP_W'(MAX_LEDS)) ? CNT_W'(MAX_LEDS) : CNT_W'(cfg_ext);
  assign lb_round  = (CNT_W + 1)'(count_use) + (CNT_W + 1)'(LATCH_ROUND);
  assign lb_full   = lb_round >> LATCH_SHIFT;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count_q <= LED_COUNT_RESET;
    end else if (cfg_valid_i) begin
      led_count_q <= cfg_led_count_i;
    end
  end

  // Store write port: clearing pass or a pixel write.
  always_comb begin
    wr_en   = cmd_i.clr_step || cmd_i.pix_write;
    wr_addr = cmd_i.clr_step ? clr_q : ROW_W'(pixel_index_i);
    wr_data = cmd_i.clr_step ? {OFF_BYTE, OFF_BYTE, OFF_BYTE}
                             : {green_i | TOP_BIT, red_i | TOP_BIT, blue_i | TOP_BIT};
  end

  // Pixel store, one LED per row, green in the upper byte.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[led_d];
  end

  // Clearing pass row counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + ROW_W'(1);
    end
  end

  // Current byte of the prefetched LED row.
  always_comb begin
    unique case (byte_q)
      2'd0:    cur_byte = rd_q[3*COLOR_W-1:2*COLOR_W];
      2'd1:    cur_byte = rd_q[2*COLOR_W-1:COLOR_W];
      default: cur_byte = rd_q[COLOR_W-1:0];
    endcase
  end

  // Bit selection and frame position update.
  always_comb begin
    src_byte = (bit_q == 3'd0) ? cur_byte : shift_q;
    bit_v    = cmd_i.data_phase && src_byte[COLOR_W-1];
    byte_end = (bit_q == 3'd7);
    led_d    = led_q;
    byte_d   = byte_q;
    bit_d    = bit_q;
    lb_cnt_d = lb_cnt_q;
    shift_d  = shift_q;
    if (cmd_i.start) begin
      led_d    = '0;
      byte_d   = '0;
      bit_d    = '0;
      lb_cnt_d = '0;
    end else if (cmd_i.tick) begin
      bit_d   = bit_q + 3'd1;
      shift_d = src_byte << 1;
      if (byte_end) begin
        if (cmd_i.data_phase) begin
          if (byte_q == LAST_BYTE) begin
            byte_d = '0;
            led_d  = status_o.data_last ? '0 : led_q + ROW_W'(1);
          end else begin
            byte_d = byte_q + 2'd1;
          end
        end else begin
          lb_cnt_d = lb_cnt_q + LB_W'(1);
        end
      end
    end
  end

  // Frame position registers and latched frame lengths.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_q      <= '0;
      byte_q     <= '0;
      bit_q      <= '0;
      lb_cnt_q   <= '0;
      led_last_q <= '0;
      lb_last_q  <= '0;
    end else begin
      led_q    <= led_d;
      byte_q   <= byte_d;
      bit_q    <= bit_d;
      lb_cnt_q <= lb_cnt_d;
      if (cmd_i.start) begin
        led_last_q <= ROW_W'(count_use - CNT_W'(1));
        lb_last_q  <= LB_W'(lb_full - (CNT_W + 1)'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

  // Output register for serial bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.tick) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick) begin
      data_bit_q <= bit_v;
      last_bit_q <= !cmd_i.data_phase && status_o.latch_last;
    end
  end

  // Status to the controller.
  always_comb begin
    status_o.clr_last   = (clr_q == LAST_ROW);
    status_o.count_zero = (count_use == '0);
    status_o.pix_ok     = (PCMP_W'(pixel_index_i) < PCMP_W'(count_use));
    status_o.data_last  = (led_q == led_last_q) && (byte_q == LAST_BYTE) && byte_end;
    status_o.latch_last = (lb_cnt_q == lb_last_q) && byte_end;
    status_o.out_busy   = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign data_bit_o  = data_bit_q;
  assign last_bit_o  = last_bit_q;

endmodule

// ===== design/led_strip_frame_serializer.sv =====
// Output: a tick's serial bit is registered and shown in the cycle after its acceptance.
// Throughput: one item per cycle while results are taken; the row prefetch from the
// pixel store keeps ticks back to back across byte and LED boundaries.
// Reset: the pixel store is cleared to all LEDs off by a pass over all MAX_LEDS rows,
// one row per cycle, during which no item is accepted; configuration is always taken.
// ---------------------------------------------------------------------------
// LED strip frame serializer top level
// Two-wire LED strip controller: pixel store, frame and latch serialization.
// ---------------------------------------------------------------------------
module led_strip_frame_serializer
  import lsfs_pkg::*;
#(
  parameter int MAX_LEDS = MAX_LEDS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_W-1:0]     cfg_led_count_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [FUNC_W-1:0]    func_i,
  input  logic [PIX_IDX_W-1:0] pixel_index_i,
  input  logic [COLOR_W-1:0]   red_i,
  input  logic [COLOR_W-1:0]   green_i,
  input  logic [COLOR_W-1:0]   blue_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 data_bit_o,
  output logic                 last_bit_o
);

  lsfs_cmd_t    cmd;
  lsfs_status_t status;
  logic         cfg_write;

  // The count register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  lsfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lsfs_datapath #(
    .MAX_LEDS (MAX_LEDS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_write),
    .cfg_led_count_i (cfg_led_count_i),
    .pixel_index_i   (pixel_index_i),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .data_bit_o      (data_bit_o),
    .last_bit_o      (last_bit_o)
  );

endmodule

// ===== design/lsfs_checker.sv =====
// ---------------------------------------------------------------------------
// LED strip frame serializer checker
// Port-level assertions on the output register and its link to ticks.
// ---------------------------------------------------------------------------
`include "led_strip_frame_serializer_macros.svh"

module lsfs_checker
  import lsfs_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic [FUNC_W-1:0] func_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              data_bit_o,
  input logic              last_bit_o
);

  // A stalled result stays presented with its payload held.
  `LSFS_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `LSFS_ASSERT_NXT(a_out_stable, out_valid_o && !out_ready_i,
                   $stable(data_bit_o) && $stable(last_bit_o))

  // A new result appears only after an accepted tick transaction.
  `LSFS_ASSERT_IMP(a_out_from_tick, $rose(out_valid_o),
                   $past(in_valid_i && in_ready_o && (func_i == FUNC_TICK)))

  // Input is never taken while a stalled result occupies the output register.
  `LSFS_ASSERT_IMP(a_no_overrun, in_ready_o && out_valid_o, out_ready_i)

endmodule

bind led_strip_frame_serializer lsfs_checker u_lsfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .func_i      (func_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .data_bit_o  (data_bit_o),
  .last_bit_o  (last_bit_o)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LED strip frame serializer testbench
// Drives set-pixel, show, latch and tick transactions with random idling,
// predicts each serial bit from a private model of the pixel store and the
// frame engine or takes it from a pinned row, and compares each returned bit in order.
// ---------------------------------------------------------------------------
module tb_top;
  import lsfs_pkg::*;

  localparam int STRIP_MAX     = MAX_LEDS_DEFAULT;
  localparam int ITEM_TARGET   = 1850;
  localparam int CALM_SPAN     = 400;
  localparam int SHOW_MAX_LEDS = 16;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 16;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int LONG_HOLD     = 300;
  localparam int INTRO_ROWS    = 21;
  localparam int IDLE_DENS [3] = '{0, 3, 8};

  // One serial bit as seen on the strip outputs.
  typedef struct packed {
    logic data;
    logic last;
  } strip_bit_t;

  typedef enum logic {
    ROW_CFG,
    ROW_ITEM
  } row_kind_e;

  // One row of the directed part; pinned rows carry their own expectation.
  typedef struct {
    row_kind_e         kind;
    logic [CFG_W-1:0]  strip_len;
    func_e             op;
    logic [9:0]        idx;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    int                reps;
    bit                pin;
    bit                pin_data;
    bit                pin_last;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_W-1:0]     cfg_led_count_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [FUNC_W-1:0]    func_i;
  logic [PIX_IDX_W-1:0] pixel_index_i;
  logic [COLOR_W-1:0]   red_i;
  logic [COLOR_W-1:0]   green_i;
  logic [COLOR_W-1:0]   blue_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 data_bit_o;
  logic                 last_bit_o;

  // Model of the block: configuration, pixel store and frame engine.
  logic [CFG_W-1:0]   strip_len;
  logic [COLOR_W-1:0] led_bytes [STRIP_MAX*BYTES_PER_LED];
  bit                 frame_busy;
  bit                 latch_run;
  int unsigned        byte_pos;
  logic [2:0]         bit_pos;
  logic [COLOR_W-1:0] shift_reg;
  int unsigned        data_len;
  int unsigned        total_len;

  // Serial bits predicted but not yet returned, oldest first.
  strip_bit_t serial_bits_due [$];

  // Stimulus bookkeeping.
  logic [CFG_W-1:0] cur_len;
  int unsigned      ticks_left;
  int unsigned      eff_items;
  int unsigned      gap_den;
  int unsigned      rx_den;
  int unsigned      err_count;
  bit               hold_req;
  logic             pin_on;
  logic             pin_data;
  logic             pin_last;

  stim_row_t intro [INTRO_ROWS] = '{
    '{ROW_ITEM, 11'd0,    FUNC_TICK,      10'd0,    8'h00, 8'h00, 8'h00, 1, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_SET_PIXEL, 10'd1023, 8'hff, 8'hff, 8'hff, 1, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_SET_PIXEL, 10'd0,    8'h00, 8'h00, 8'h00, 1, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_SET_PIXEL, 10'd31,   8'hff, 8'hff, 8'hff, 1, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_SET_PIXEL, 10'd32,   8'h55, 8'haa, 8'h55, 1, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_LATCH,     10'd0,    8'h00, 8'h00, 8'h00, 1, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_TICK,      10'd0,    8'h00, 8'h00, 8'h00, 4, 1'b1, 1'b0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_SHOW,      10'd0,    8'h00, 8'h00, 8'h00, 1, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_SET_PIXEL, 10'd1,    8'h12, 8'h34, 8'h56, 1, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_LATCH,     10'd0,    8'h00, 8'h00, 8'h00, 1, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_TICK,      10'd0,    8'hff, 8'hff, 8'hff, 4, 1'b1, 1'b0, 1'b1},
    '{ROW_ITEM, 11'd0,    FUNC_TICK,      10'd1023, 8'h00, 8'h00, 8'h00, 1, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG,  11'd0,    FUNC_SET_PIXEL, 10'd0,    8'h00, 8'h00, 8'h00, 1, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_SET_PIXEL, 10'd0,    8'hab, 8'hcd, 8'hef, 1, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_SHOW,      10'd0,    8'h00, 8'h00, 8'h00, 1, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_LATCH,     10'd0,    8'h00, 8'h00, 8'h00, 1, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_TICK,      10'd0,    8'h00, 8'h00, 8'h00, 1, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG,  11'd2047, FUNC_SET_PIXEL, 10'd0,    8'h00, 8'h00, 8'h00, 1, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_SET_PIXEL, 10'd1023, 8'ha5, 8'h5a, 8'hc3, 1, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG,  11'd1,    FUNC_SET_PIXEL, 10'd0,    8'h00, 8'h00, 8'h00, 1, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_SET_PIXEL, 10'd1,    8'h3c, 8'hc3, 8'h81, 1, 1'b0, 1'b0, 1'b0}
  };

  led_strip_frame_serializer #(
    .MAX_LEDS(STRIP_MAX)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_led_count_i(cfg_led_count_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .pixel_index_i  (pixel_index_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .data_bit_o     (data_bit_o),
    .last_bit_o     (last_bit_o)
  );

  // Clock with a 2 ns period.
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Advances the model by one transaction; returns 1 when a serial bit results.
  function automatic bit predict_serial_bit(input func_e op,
                                            input logic [PIX_IDX_W-1:0] idx,
                                            input logic [COLOR_W-1:0] r, g, b,
                                            output strip_bit_t bit_out);
    int unsigned n;
    int unsigned base;
    int unsigned latch_bytes;
    int unsigned span;
    bit final_bit;
    bit_out = '0;
    if (op == FUNC_TICK) begin
      if (!frame_busy) return 1'b0;
      // A new byte is fetched at each byte boundary; latch bytes are zero.
      if (bit_pos == 3'd0) begin
        shift_reg = (!latch_run && byte_pos < data_len) ? led_bytes[byte_pos] : 8'h00;
      end
      final_bit = (byte_pos + 1 == total_len) && (bit_pos == 3'd7);
      bit_out.data = shift_reg[7];
      bit_out.last = final_bit;
      shift_reg = shift_reg << 1;
      bit_pos = bit_pos + 3'd1;
      if (bit_pos == 3'd0) byte_pos++;
      if (final_bit) begin
        frame_busy = 1'b0;
        latch_run  = 1'b0;
        byte_pos   = 0;
        bit_pos    = 3'd0;
      end
      return 1'b1;
    end
    if (frame_busy) return 1'b0;
    n = (strip_len > STRIP_MAX) ? STRIP_MAX : strip_len;
    case (op)
      FUNC_SET_PIXEL: begin
        if (idx < n) begin
          base = idx * BYTES_PER_LED;
          led_bytes[base]     = g | TOP_BIT;
          led_bytes[base + 1] = r | TOP_BIT;
          led_bytes[base + 2] = b | TOP_BIT;
        end
      end
      default: begin
        latch_bytes = (n + LATCH_ROUND) >> LATCH_SHIFT;
        span = (op == FUNC_SHOW) ? BYTES_PER_LED * n : 0;
        if (span + latch_bytes != 0) begin
          frame_busy = 1'b1;
          latch_run  = (op == FUNC_LATCH);
          data_len   = span;
          total_len  = span + latch_bytes;
          byte_pos   = 0;
          bit_pos    = 3'd0;
          shift_reg  = 8'h00;
        end
      end
    endcase
    return 1'b0;
  endfunction

  task automatic note_mismatch(input string what, input logic want, input logic got);
    err_count++;
    $display("%0t: %s mismatch, expected %0b, actual %0b", $time, what, want, got);
  endtask

  // Tracks accepted transactions: configuration, prediction and bit checking.
  always @(posedge clk_i) begin
    strip_bit_t guess;
    strip_bit_t want;
    bit has_bit;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) strip_len = cfg_led_count_i;
      if (in_valid_i && in_ready_o) begin
        has_bit = predict_serial_bit(func_e'(func_i), pixel_index_i, red_i, green_i,
                                     blue_i, guess);
        if (has_bit) begin
          if (pin_on) begin
            guess.data = pin_data;
            guess.last = pin_last;
          end
          serial_bits_due.push_back(guess);
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (serial_bits_due.size() == 0) begin
          err_count++;
          $display("%0t: serial bit with no expectation waiting, expected none, actual %0b/%0b",
                   $time, data_bit_o, last_bit_o);
        end else begin
          want = serial_bits_due.pop_front();
          if (want.data !== data_bit_o) note_mismatch("data bit", want.data, data_bit_o);
          if (want.last !== last_bit_o) note_mismatch("last bit", want.last, last_bit_o);
        end
      end
    end
  end

  // Receiver: random short stalls, plus one long hold on request.
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (rx_den != 0 && $urandom_range(0, rx_den - 1) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Offers one transaction and waits for its acceptance; must start at a clock edge.
  task automatic send_strip_item(input func_e op, input logic [PIX_IDX_W-1:0] idx,
                                 input logic [COLOR_W-1:0] r, g, b);
    int unsigned n;
    if (gap_den != 0 && $urandom_range(0, gap_den - 1) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= op;
    pixel_index_i <= idx;
    red_i         <= r;
    green_i       <= g;
    blue_i        <= b;
    do @(posedge clk_i); while (!in_ready_o);
    // Keep track of the frame length so that stimulus knows when the block is busy.
    n = (cur_len > STRIP_MAX) ? STRIP_MAX : cur_len;
    case (op)
      FUNC_TICK: begin
        if (ticks_left != 0) begin
          ticks_left--;
          eff_items++;
        end
      end
      FUNC_SET_PIXEL: if (ticks_left == 0 && idx < n) eff_items++;
      default: begin
        if (ticks_left == 0 && n != 0) begin
          ticks_left = ((op == FUNC_SHOW ? BYTES_PER_LED * n : 0) +
                        ((n + LATCH_ROUND) >> LATCH_SHIFT)) * 8;
          eff_items++;
        end
      end
    endcase
  endtask

  // Lowers valid and waits until every predicted bit has been returned or the guard runs out.
  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
      guard++;
    end while (serial_bits_due.size() != 0 && guard < DRAIN_LIMIT);
  endtask

  task automatic write_strip_len(input logic [CFG_W-1:0] len);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i     <= 1'b1;
    cfg_led_count_i <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_len = len;
  endtask

  function automatic logic [PIX_IDX_W-1:0] pick_index(input int unsigned n);
    if (n != 0 && $urandom_range(0, 4) != 0) return PIX_IDX_W'($urandom_range(0, n - 1));
    return PIX_IDX_W'($urandom());
  endfunction

  // Any function with random fields; long frames are swapped for latch runs.
  task automatic send_noise(input int unsigned n);
    func_e op;
    op = func_e'($urandom_range(0, 3));
    if (op == FUNC_SHOW && ticks_left == 0 && n > SHOW_MAX_LEDS) op = FUNC_LATCH;
    send_strip_item(op, pick_index(n), COLOR_W'($urandom()), COLOR_W'($urandom()),
                    COLOR_W'($urandom()));
  endtask

  // Clocks out the rest of the active frame, with ignored transactions mixed in.
  // Mode 1 asks the receiver for a long hold; mode 2 parks the sender mid-frame.
  task automatic run_ticks(input int mode, input int unsigned n);
    int unsigned k;
    k = 0;
    while (ticks_left != 0) begin
      if (mode == 1 && k == 10) hold_req = 1'b1;
      if (mode == 2 && k == 40) wait_drained();
      if ($urandom_range(0, 15) == 0) begin
        send_noise(n);
      end else begin
        send_strip_item(FUNC_TICK, PIX_IDX_W'($urandom()), COLOR_W'($urandom()),
                        COLOR_W'($urandom()), COLOR_W'($urandom()));
      end
      k++;
    end
  endtask

  // Watchdog.
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Main sequence: reset, directed table, random phases, drain.
  initial begin
    int row;
    int rep;
    int phase_no;
    int ops;
    int op_mode;
    int pick;
    int unsigned n;
    logic [CFG_W-1:0] len;
    func_e start_op;

    // Model after reset.
    strip_len  = LED_COUNT_RESET;
    for (int k = 0; k < STRIP_MAX * BYTES_PER_LED; k++) led_bytes[k] = OFF_BYTE;
    frame_busy = 1'b0;
    latch_run  = 1'b0;
    byte_pos   = 0;
    bit_pos    = 3'd0;
    shift_reg  = 8'h00;
    data_len   = 0;
    total_len  = 0;

    cur_len    = LED_COUNT_RESET;
    ticks_left = 0;
    eff_items  = 0;
    err_count  = 0;
    gap_den    = 3;
    rx_den     = 3;
    hold_req   = 1'b0;

    rst_ni          <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_led_count_i <= '0;
    in_valid_i      <= 1'b0;
    func_i          <= FUNC_SET_PIXEL;
    pixel_index_i   <= '0;
    red_i           <= '0;
    green_i         <= '0;
    blue_i          <= '0;
    pin_on          <= 1'b0;
    pin_data        <= 1'b0;
    pin_last        <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: reset count, extremes, ignored items and register extremes.
    for (row = 0; row < INTRO_ROWS; row++) begin
      if (intro[row].kind == ROW_CFG) begin
        write_strip_len(intro[row].strip_len);
      end else begin
        for (rep = 0; rep < intro[row].reps; rep++) begin
          pin_on   <= intro[row].pin;
          pin_data <= intro[row].pin_data;
          pin_last <= (rep == intro[row].reps - 1) ? intro[row].pin_last : 1'b0;
          send_strip_item(intro[row].op, intro[row].idx, intro[row].red,
                          intro[row].green, intro[row].blue);
        end
      end
    end
    pin_on <= 1'b0;
    eff_items = 0;

    // Random phases, each with its own strip length, and an idling mix per operation.
    phase_no = 0;
    while (eff_items < ITEM_TARGET) begin
      case (phase_no)
        0: len = 11'd12;
        1: len = 11'd9;
        default: begin
          case ($urandom_range(0, 15))
            0:       len = 11'd0;
            1:       len = 11'd1;
            2:       len = 11'd2047;
            3:       len = 11'd1024;
            4:       len = 11'd1023;
            5:       len = 11'd31;
            6:       len = 11'd32;
            7:       len = 11'd33;
            default: len = CFG_W'($urandom_range(1, 12));
          endcase
        end
      endcase
      write_strip_len(len);
      n = (len > STRIP_MAX) ? STRIP_MAX : len;
      op_mode = (phase_no < 2) ? phase_no + 1 : 0;
      ops = $urandom_range(3, 8);
      while (ops != 0 && eff_items < ITEM_TARGET) begin
        // The closing stretch of the run has no idling on either side.
        if (eff_items + CALM_SPAN >= ITEM_TARGET) begin
          gap_den = 0;
          rx_den  = 0;
        end else begin
          gap_den = IDLE_DENS[$urandom_range(0, 2)];
          rx_den  = IDLE_DENS[$urandom_range(0, 2)];
        end
        pick = (op_mode != 0) ? 0 : $urandom_range(0, 9);
        start_op = (n <= SHOW_MAX_LEDS && (op_mode != 0 || $urandom_range(0, 2) != 0)) ?
                   FUNC_SHOW : FUNC_LATCH;
        if (pick < 6) begin
          // Well-formed: some pixels, a frame or latch start, then all its ticks.
          repeat ($urandom_range(0, 4)) begin
            send_strip_item(FUNC_SET_PIXEL, pick_index(n), COLOR_W'($urandom()),
                            COLOR_W'($urandom()), COLOR_W'($urandom()));
          end
          send_strip_item(start_op, PIX_IDX_W'($urandom()), COLOR_W'($urandom()),
                          COLOR_W'($urandom()), COLOR_W'($urandom()));
          run_ticks(op_mode, n);
          op_mode = 0;
        end else if (pick < 8) begin
          send_noise(n);
        end else begin
          // Broken: a start followed by a random mix of ticks and noise that may stop short of its end.
          send_strip_item(start_op, PIX_IDX_W'($urandom()), COLOR_W'($urandom()),
                          COLOR_W'($urandom()), COLOR_W'($urandom()));
          repeat ($urandom_range(1, 20)) begin
            if ($urandom_range(0, 2) == 0) begin
              send_noise(n);
            end else begin
              send_strip_item(FUNC_TICK, PIX_IDX_W'($urandom()), COLOR_W'($urandom()),
                              COLOR_W'($urandom()), COLOR_W'($urandom()));
            end
          end
        end
        ops--;
      end
      run_ticks(0, n);
      phase_no++;
    end

    // Drain and close.
    gap_den = 0;
    rx_den  = 0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (serial_bits_due.size() != 0) begin
      err_count++;
      $display("%0t: serial bits never returned, expected %0d more, actual 0",
               $time, serial_bits_due.size());
    end
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/lsfs_pkg.sv
design/lsfs_ctrl.sv
design/lsfs_datapath.sv
design/led_strip_frame_serializer.sv
design/lsfs_checker.sv
verif/tb_top.sv
